>>> src/lfpm_pkg.sv
// lfpm_pkg: shared widths, reset values, register indexes and output bounds
// for the line-follow pid motor mixer
// depends on nothing; used by the top level and its port checker
`default_nettype none

package lfpm_pkg;

    // field widths
    localparam int POS_W     = 14;
    localparam int ERR_W     = 14;
    localparam int GAIN_W    = 24;
    localparam int SPD_W     = 8;
    localparam int OUT_W     = 19;
    localparam int CFG_IDX_W = 3;
    localparam int FRAC_W    = 16;

    // default error history depth
    localparam int WINDOW_DEF = 5;

    // registered stages from input to result register
    localparam int PIPE_DEPTH = 4;

    // line centre
    localparam logic [POS_W-1:0] CENTRE = 14'd4500;

    // lowest command value, -262144
    localparam logic signed [OUT_W-1:0] OUT_LOW = 19'sh40000;

    // register reset values
    localparam logic [GAIN_W-1:0] GAIN_PROP_RST   = 24'd131;
    localparam logic [GAIN_W-1:0] GAIN_INTEG_RST  = 24'd66;
    localparam logic [GAIN_W-1:0] GAIN_DERIV_RST  = 24'd983040;
    localparam logic [GAIN_W-1:0] GAIN_COMMON_RST = 24'd0;
    localparam logic [SPD_W-1:0]  BASE_LEFT_RST   = 8'd92;
    localparam logic [SPD_W-1:0]  BASE_RIGHT_RST  = 8'd92;
    localparam logic [SPD_W-1:0]  MAX_LEFT_RST    = 8'd100;
    localparam logic [SPD_W-1:0]  MAX_RIGHT_RST   = 8'd100;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_PROP,
        REG_GAIN_INTEG,
        REG_GAIN_DERIV,
        REG_GAIN_COMMON,
        REG_BASE_LEFT,
        REG_BASE_RIGHT,
        REG_MAX_LEFT,
        REG_MAX_RIGHT
    } cfg_reg_t;

endpackage

`default_nettype wire

>>> src/line_follow_pid_motor_mix_top.sv
// line_follow_pid_motor_mix_top: pid steering from a line position, mixed
// into clamped left and right motor commands through a four-stage pipeline
// depends on lfpm_pkg
//
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  in      | in_valid, in_ready, line_position    | into block
//  out     | out_valid, out_ready, speed_left/right| out of block
//  cfg     | cfg_valid, cfg_ready, cfg_index/data | into block
//
// one item per cycle until a stalled result fills the pipeline; an item
// goes through the error/history stage, multiplier stage, drive stage and result
// register once accepted. the error history and abs-error sum update as the item is taken
// reset clears the history, the window sum, the pipeline valids and loads the
// register defaults; cfg_ready is always high
// each stage moves on when the stage after it is empty or moving, so a stalled
// result only holds back input once every stage behind it is full
`default_nettype none

module line_follow_pid_motor_mix_top #(
    parameter int WINDOW = lfpm_pkg::WINDOW_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // item input
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [lfpm_pkg::POS_W-1:0]           line_position,
    // result output
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic signed [lfpm_pkg::OUT_W-1:0]         speed_left,
    output logic signed [lfpm_pkg::OUT_W-1:0]         speed_right,
    // register writes
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [lfpm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [lfpm_pkg::GAIN_W-1:0]          cfg_data
);

    import lfpm_pkg::*;

    // width of the windowed abs-error sum
    localparam int AB_W   = $clog2(WINDOW * (2 ** (ERR_W - 1)) + 1);
    localparam int DIFF_W = ERR_W + 1;
    // signed products and their sum
    localparam int PROD_W = AB_W + GAIN_W + 1;
    localparam int ACC_W  = PROD_W + 2;
    localparam int DRV_W  = ACC_W - FRAC_W;
    // common slow-down product and its integer part
    localparam int SLOW_W = AB_W + GAIN_W;
    localparam int SHI_W  = SLOW_W - FRAC_W;
    // side arithmetic before clamping
    localparam int SIDE_W = ((DRV_W > SHI_W) ? DRV_W : SHI_W) + 3;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [GAIN_W-1:0] gain_prop_reg, gain_integ_reg, gain_deriv_reg, gain_common_reg;
    logic [SPD_W-1:0]  base_left_reg, base_right_reg, max_left_reg, max_right_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_prop_reg   <= GAIN_PROP_RST;
            gain_integ_reg  <= GAIN_INTEG_RST;
            gain_deriv_reg  <= GAIN_DERIV_RST;
            gain_common_reg <= GAIN_COMMON_RST;
            base_left_reg   <= BASE_LEFT_RST;
            base_right_reg  <= BASE_RIGHT_RST;
            max_left_reg    <= MAX_LEFT_RST;
            max_right_reg   <= MAX_RIGHT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_GAIN_PROP:   gain_prop_reg   <= cfg_data;
                REG_GAIN_INTEG:  gain_integ_reg  <= cfg_data;
                REG_GAIN_DERIV:  gain_deriv_reg  <= cfg_data;
                REG_GAIN_COMMON: gain_common_reg <= cfg_data;
                REG_BASE_LEFT:   base_left_reg   <= cfg_data[SPD_W-1:0];
                REG_BASE_RIGHT:  base_right_reg  <= cfg_data[SPD_W-1:0];
                REG_MAX_LEFT:    max_left_reg    <= cfg_data[SPD_W-1:0];
                REG_MAX_RIGHT:   max_right_reg   <= cfg_data[SPD_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipeline flow control
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic s2_room, s3_room, out_room;
    logic in_acc;

    // a stage can load when empty or when its item is leaving
    assign out_room = !out_valid_reg || out_ready;
    assign s3_room  = !s3_valid_reg || out_room;
    assign s2_room  = !s2_valid_reg || s3_room;
    assign in_ready = !s1_valid_reg || s2_room;
    assign in_acc   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (s2_room)
                s2_valid_reg <= s1_valid_reg;
            if (s3_room)
                s3_valid_reg <= s2_valid_reg;
            if (out_room)
                out_valid_reg <= s3_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

    // ------------------------------------------------------------------
    // error, history and running abs-error sum (taken at input accept)
    // ------------------------------------------------------------------
    function automatic logic [ERR_W-1:0] abs_err(input logic signed [ERR_W-1:0] e);
        // the most negative error maps onto its magnitude as an unsigned value
        return e[ERR_W-1] ? ERR_W'(-e) : ERR_W'(e);
    endfunction

    logic signed [ERR_W-1:0]  err_hist_reg [WINDOW];
    logic [AB_W-1:0]          absum_reg;
    logic signed [ERR_W-1:0]  err_new;
    logic signed [DIFF_W-1:0] diff_new;
    logic [AB_W-1:0]          absum_next;

    // 14-bit subtract, wraps for positions out of range
    assign err_new  = signed'(CENTRE - line_position);
    assign diff_new = DIFF_W'(err_new) - DIFF_W'(err_hist_reg[0]);

    // add the newest magnitude, drop the one falling out of the window
    assign absum_next = absum_reg + AB_W'(abs_err(err_new))
                      - AB_W'(abs_err(err_hist_reg[WINDOW-1]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW; i++)
                err_hist_reg[i] <= '0;
            absum_reg <= '0;
        end
        else if (in_acc)
        begin
            for (int i = 1; i < WINDOW; i++)
                err_hist_reg[i] <= err_hist_reg[i-1];
            err_hist_reg[0] <= err_new;
            absum_reg       <= absum_next;
        end
    end

    // stage 1 payload
    logic signed [ERR_W-1:0]  s1_err_reg;
    logic signed [DIFF_W-1:0] s1_diff_reg;
    logic [AB_W-1:0]          s1_absum_reg;

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_err_reg   <= err_new;
            s1_diff_reg  <= diff_new;
            s1_absum_reg <= absum_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: gain multiplies
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0] p_prod, i_prod, d_prod;
    logic [SLOW_W-1:0]        slow_prod;

    assign p_prod = PROD_W'(s1_err_reg) * PROD_W'(signed'({1'b0, gain_prop_reg}));
    assign i_prod = PROD_W'(signed'({1'b0, s1_absum_reg}))
                  * PROD_W'(signed'({1'b0, gain_integ_reg}));
    assign d_prod = PROD_W'(s1_diff_reg) * PROD_W'(signed'({1'b0, gain_deriv_reg}));
    assign slow_prod = SLOW_W'(s1_absum_reg) * SLOW_W'(gain_common_reg);

    logic signed [PROD_W-1:0] s2_p_reg, s2_i_reg, s2_d_reg;
    logic [SLOW_W-1:0]        s2_slow_reg;

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s2_room)
        begin
            s2_p_reg    <= p_prod;
            s2_i_reg    <= i_prod;
            s2_d_reg    <= d_prod;
            s2_slow_reg <= slow_prod;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: drive sum (q8.16 gains, 16 fraction bits) to integer toward zero
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0] acc_sum, acc_adj;
    logic signed [DRV_W-1:0] drive;

    assign acc_sum = ACC_W'(s2_p_reg) + ACC_W'(s2_i_reg) + ACC_W'(s2_d_reg);
    // bias negative sums so the shift rounds toward zero
    assign acc_adj = acc_sum + (acc_sum[ACC_W-1] ? ACC_W'((2 ** FRAC_W) - 1) : ACC_W'(0));
    assign drive   = signed'(acc_adj[ACC_W-1:FRAC_W]);

    logic signed [DRV_W-1:0] s3_drive_reg;
    logic [SHI_W-1:0]        s3_slow_hi_reg;
    logic                    s3_slow_frac_reg;

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && s3_room)
        begin
            s3_drive_reg     <= drive;
            s3_slow_hi_reg   <= s2_slow_reg[SLOW_W-1:FRAC_W];
            s3_slow_frac_reg <= |s2_slow_reg[FRAC_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // result stage: side mix, truncation and clamping
    // ------------------------------------------------------------------
    // trunc(((base + drv) * 2^16 - slow) / 2^16): with t = base + drv - floor(slow / 2^16),
    // a positive t with a fractional slow part loses one more, otherwise t stands
    function automatic logic signed [OUT_W-1:0] side_speed(
        input logic [SPD_W-1:0]         base,
        input logic signed [SIDE_W-1:0] drv,
        input logic [SHI_W-1:0]         s_hi,
        input logic                     frac_nz,
        input logic [SPD_W-1:0]         maxv
    );
        logic signed [SIDE_W-1:0] t;
        logic signed [SIDE_W-1:0] v;
        logic signed [SIDE_W-1:0] top;
        t   = SIDE_W'(signed'({1'b0, base})) + drv - SIDE_W'(signed'({1'b0, s_hi}));
        v   = (!t[SIDE_W-1] && (t != '0) && frac_nz) ? t - SIDE_W'(1) : t;
        top = SIDE_W'(signed'({1'b0, maxv}));
        if (v > top)
            return OUT_W'(top);
        else if (v < SIDE_W'(OUT_LOW))
            return OUT_LOW;
        else
            return OUT_W'(v);
    endfunction

    logic signed [SIDE_W-1:0] drive_wide;
    logic signed [OUT_W-1:0]  left_next, right_next;

    assign drive_wide = SIDE_W'(s3_drive_reg);
    assign left_next  = side_speed(base_left_reg, drive_wide, s3_slow_hi_reg,
                                   s3_slow_frac_reg, max_left_reg);
    assign right_next = side_speed(base_right_reg, -drive_wide, s3_slow_hi_reg,
                                   s3_slow_frac_reg, max_right_reg);

    logic signed [OUT_W-1:0] speed_left_reg, speed_right_reg;

    always_ff @(posedge clk)
    begin
        if (s3_valid_reg && out_room)
        begin
            speed_left_reg  <= left_next;
            speed_right_reg <= right_next;
        end
    end

    assign speed_left  = speed_left_reg;
    assign speed_right = speed_right_reg;

endmodule

`default_nettype wire

>>> src/lfpm_checker.sv
// lfpm_checker: port-level checks on the line-follow pid motor mixer
// depends on lfpm_pkg; bound to line_follow_pid_motor_mix_top below
`default_nettype none

module lfpm_checker (
    input wire logic                                 clk,
    input wire logic                                 rst_n,
    input wire logic                                 in_valid,
    input wire logic                                 in_ready,
    input wire logic [lfpm_pkg::POS_W-1:0]           line_position,
    input wire logic                                 out_valid,
    input wire logic                                 out_ready,
    input wire logic signed [lfpm_pkg::OUT_W-1:0]    speed_left,
    input wire logic signed [lfpm_pkg::OUT_W-1:0]    speed_right,
    input wire logic                                 cfg_valid,
    input wire logic                                 cfg_ready,
    input wire logic [lfpm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input wire logic [lfpm_pkg::GAIN_W-1:0]          cfg_data
);

    import lfpm_pkg::*;

    localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

    // items in flight, seen from the ports
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    // copies of the clamp registers
    logic [SPD_W-1:0] max_left_reg, max_right_reg;

    assign cnt_next = cnt_reg + CNT_W'(in_valid && in_ready) - CNT_W'(out_valid && out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            max_left_reg  <= MAX_LEFT_RST;
            max_right_reg <= MAX_RIGHT_RST;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (cfg_valid && cfg_ready && cfg_reg_t'(cfg_index) == REG_MAX_LEFT)
                max_left_reg <= cfg_data[SPD_W-1:0];
            if (cfg_valid && cfg_ready && cfg_reg_t'(cfg_index) == REG_MAX_RIGHT)
                max_right_reg <= cfg_data[SPD_W-1:0];
        end
    end

    // a waiting result holds still
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(speed_left) && $stable(speed_right))
        else $error("result changed while stalled");

    // an empty result register never blocks input
    a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    // no result without an item behind it, never more in flight than stages
    a_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid || (cnt_reg != '0)) && (cnt_reg <= CNT_W'(PIPE_DEPTH)))
        else $error("item count out of step with results");

    // commands respect the upper clamps
    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (speed_left <= OUT_W'(signed'({1'b0, max_left_reg})))
                   && (speed_right <= OUT_W'(signed'({1'b0, max_right_reg}))))
        else $error("command above its clamp");

endmodule

bind line_follow_pid_motor_mix_top lfpm_checker u_lfpm_checker (.*);

`default_nettype wire
